FILE: rtl/brf_pkg.sv
// shared types and constants of the banked register file
// item structs, opcode and condition codes, mode numbers; no dependencies
package brf_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int LIVE_DEPTH  = 16;
   localparam int HIGH_DEPTH  = 5;
   localparam int HIGH_BASE   = 8;
   localparam int SP_DEPTH    = 6;
   localparam int SPSR_DEPTH  = 5;

   localparam logic [3:0] SP_INDEX = 4'd13;
   localparam logic [3:0] LR_INDEX = 4'd14;

   localparam logic [2:0] MODE_USER    = 3'd0;
   localparam logic [2:0] MODE_FIQ     = 3'd1;
   localparam logic [2:0] MODE_UNDEF   = 3'd5;
   localparam logic [2:0] MODE_SYSTEM  = 3'd6;
   localparam logic [2:0] MODE_INVALID = 3'd7;

   typedef enum logic [2:0] {
      OP_READ_REG   = 3'd0,
      OP_WRITE_REG  = 3'd1,
      OP_SWITCH     = 3'd2,
      OP_READ_SPSR  = 3'd3,
      OP_WRITE_SPSR = 3'd4,
      OP_WRITE_FLAG = 3'd5,
      OP_TEST_COND  = 3'd6
   } brf_op_type;

   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14,
      COND_NV = 4'd15
   } brf_cond_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [3:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_value;
      logic [2:0]            new_mode;
      logic [3:0]            cond_code;
      logic [3:0]            flag_bits;
   } brf_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_value;
      logic                  cond_pass;
      logic [2:0]            current_mode;
   } brf_rsp_type;

endpackage

FILE: rtl/banked_register_file_mode_switch.sv
// top level of the banked register file with mode switch and condition test
// input register, brf_core execute stage, result register; uses brf_pkg
//
// Takes one item in every clock cycle: busy stays low, and any cycle with
// start high accepts the item on req_item. The item is registered, executed
// against the register state in the following cycle, and its result is
// registered at the next clock edge. The result is then on rsp_item with rsp_strobe
// high for a single cycle. The rate is set by the single execute
// stage, which reads and updates all banks, flags and mode at once, so the
// next item sees the new state. Results cannot be held off by the receiver.
module banked_register_file_mode_switch
   import brf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  brf_req_type req_item,
   output logic        rsp_strobe,
   output brf_rsp_type rsp_item
);

   logic        req_valid_ff;
   logic        req_valid_in;
   brf_req_type req_ff;
   brf_rsp_type exec_rsp;
   logic        rsp_valid_ff;
   brf_rsp_type rsp_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_item;
      end
      if (req_valid_ff) begin
         rsp_ff <= exec_rsp;
      end
   end

   brf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .exec_valid (req_valid_ff),
      .exec_req   (req_ff),
      .exec_rsp   (exec_rsp)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: rtl/brf_core.sv
// register storage, banking on mode switch and condition test
// executes one registered item per cycle; uses brf_pkg
module brf_core
   import brf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        exec_valid,
   input  brf_req_type exec_req,
   output brf_rsp_type exec_rsp
);

   logic [DATA_WIDTH-1:0] live_ff      [LIVE_DEPTH];
   logic [DATA_WIDTH-1:0] live_in      [LIVE_DEPTH];
   logic [DATA_WIDTH-1:0] user_ff      [HIGH_DEPTH];
   logic [DATA_WIDTH-1:0] user_in      [HIGH_DEPTH];
   logic [DATA_WIDTH-1:0] fiq_ff       [HIGH_DEPTH];
   logic [DATA_WIDTH-1:0] fiq_in       [HIGH_DEPTH];
   logic [DATA_WIDTH-1:0] sp_bank_ff   [SP_DEPTH];
   logic [DATA_WIDTH-1:0] sp_bank_in   [SP_DEPTH];
   logic [DATA_WIDTH-1:0] lr_bank_ff   [SP_DEPTH];
   logic [DATA_WIDTH-1:0] lr_bank_in   [SP_DEPTH];
   logic [DATA_WIDTH-1:0] spsr_bank_ff [SPSR_DEPTH];
   logic [DATA_WIDTH-1:0] spsr_bank_in [SPSR_DEPTH];
   logic [DATA_WIDTH-1:0] spsr_live_ff;
   logic [DATA_WIDTH-1:0] spsr_live_in;
   logic [2:0]            mode_ff;
   logic [2:0]            mode_in;
   logic [3:0]            flags_ff;
   logic [3:0]            flags_in;

   logic [2:0] target;
   logic [2:0] old_slot;
   logic [2:0] new_slot;

   function automatic logic [2:0] sp_slot(input logic [2:0] m);
      return (m == MODE_SYSTEM) ? MODE_USER : m;
   endfunction

   function automatic logic has_spsr(input logic [2:0] m);
      return (m >= MODE_FIQ) && (m <= MODE_UNDEF);
   endfunction

   function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
      logic n;
      logic z;
      logic cy;
      logic v;
      logic res;
      n  = f[3];
      z  = f[2];
      cy = f[1];
      v  = f[0];
      case (brf_cond_type'(c))
         COND_EQ: res = z;
         COND_NE: res = !z;
         COND_CS: res = cy;
         COND_CC: res = !cy;
         COND_MI: res = n;
         COND_PL: res = !n;
         COND_VS: res = v;
         COND_VC: res = !v;
         COND_HI: res = cy && !z;
         COND_LS: res = !cy || z;
         COND_GE: res = (n == v);
         COND_LT: res = (n != v);
         COND_GT: res = !z && (n == v);
         COND_LE: res = z || (n != v);
         COND_AL: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

   assign target   = exec_req.new_mode;
   assign old_slot = sp_slot(mode_ff);
   assign new_slot = sp_slot(target);

   always_comb begin
      live_in      = live_ff;
      user_in      = user_ff;
      fiq_in       = fiq_ff;
      sp_bank_in   = sp_bank_ff;
      lr_bank_in   = lr_bank_ff;
      spsr_bank_in = spsr_bank_ff;
      spsr_live_in = spsr_live_ff;
      mode_in      = mode_ff;
      flags_in     = flags_ff;
      exec_rsp              = '0;
      exec_rsp.current_mode = mode_ff;
      if (exec_valid) begin
         case (brf_op_type'(exec_req.opcode))
            OP_READ_REG: begin
               exec_rsp.read_value = live_ff[exec_req.reg_index];
            end
            OP_WRITE_REG: begin
               live_in[exec_req.reg_index] = exec_req.write_value;
            end
            OP_SWITCH: begin
               if (target != MODE_INVALID) begin
                  // save outgoing bank
                  for (int i = 0; i < HIGH_DEPTH; i++) begin
                     if (mode_ff == MODE_FIQ) begin
                        fiq_in[i] = live_ff[HIGH_BASE + i];
                     end else begin
                        user_in[i] = live_ff[HIGH_BASE + i];
                     end
                  end
                  sp_bank_in[old_slot] = live_ff[SP_INDEX];
                  lr_bank_in[old_slot] = live_ff[LR_INDEX];
                  if (has_spsr(mode_ff)) begin
                     spsr_bank_in[mode_ff - 3'd1] = spsr_live_ff;
                  end
                  // load incoming bank, live value where both sides share a bank
                  for (int i = 0; i < HIGH_DEPTH; i++) begin
                     if (target == MODE_FIQ) begin
                        live_in[HIGH_BASE + i] =
                           (mode_ff == MODE_FIQ) ? live_ff[HIGH_BASE + i] : fiq_ff[i];
                     end else begin
                        live_in[HIGH_BASE + i] =
                           (mode_ff != MODE_FIQ) ? live_ff[HIGH_BASE + i] : user_ff[i];
                     end
                  end
                  if (old_slot != new_slot) begin
                     live_in[SP_INDEX] = sp_bank_ff[new_slot];
                     live_in[LR_INDEX] = lr_bank_ff[new_slot];
                  end
                  if (has_spsr(target) && (target != mode_ff)) begin
                     spsr_live_in = spsr_bank_ff[target - 3'd1];
                  end
                  mode_in               = target;
                  exec_rsp.current_mode = target;
               end
            end
            OP_READ_SPSR: begin
               exec_rsp.read_value = spsr_live_ff;
            end
            OP_WRITE_SPSR: begin
               spsr_live_in = exec_req.write_value;
            end
            OP_WRITE_FLAG: begin
               flags_in = exec_req.flag_bits;
            end
            OP_TEST_COND: begin
               exec_rsp.cond_pass = cond_holds(exec_req.cond_code, flags_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIVE_DEPTH; i++) live_ff[i] <= '0;
         for (int i = 0; i < HIGH_DEPTH; i++) begin
            user_ff[i] <= '0;
            fiq_ff[i]  <= '0;
         end
         for (int i = 0; i < SP_DEPTH; i++) begin
            sp_bank_ff[i] <= '0;
            lr_bank_ff[i] <= '0;
         end
         for (int i = 0; i < SPSR_DEPTH; i++) spsr_bank_ff[i] <= '0;
         spsr_live_ff <= '0;
         mode_ff      <= MODE_SYSTEM;
         flags_ff     <= '0;
      end else begin
         live_ff      <= live_in;
         user_ff      <= user_in;
         fiq_ff       <= fiq_in;
         sp_bank_ff   <= sp_bank_in;
         lr_bank_ff   <= lr_bank_in;
         spsr_bank_ff <= spsr_bank_in;
         spsr_live_ff <= spsr_live_in;
         mode_ff      <= mode_in;
         flags_ff     <= flags_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_switch_mode: assert property (@(posedge clock) disable iff (reset)
      exec_valid && (exec_req.opcode == OP_SWITCH) && (exec_req.new_mode != MODE_INVALID)
      |=> mode_ff == $past(exec_req.new_mode))
      else $error("mode not taken on switch");

   a_mode_hold: assert property (@(posedge clock) disable iff (reset)
      !(exec_valid && (exec_req.opcode == OP_SWITCH)) |=> $stable(mode_ff))
      else $error("mode changed without switch");

   a_reg_write: assert property (@(posedge clock) disable iff (reset)
      exec_valid && (exec_req.opcode == OP_WRITE_REG)
      |=> live_ff[$past(exec_req.reg_index)] == $past(exec_req.write_value))
      else $error("register write lost");

   a_flag_write: assert property (@(posedge clock) disable iff (reset)
      exec_valid && (exec_req.opcode == OP_WRITE_FLAG)
      |=> flags_ff == $past(exec_req.flag_bits))
      else $error("flag write lost");
`endif

endmodule
